@@ rtl/ssws_pkg.sv @@
// shared types and constants of the shell style word splitter
`default_nettype none

package ssws_pkg;

	localparam int QAW    = 2;
	localparam int QDEPTH = 1 << QAW;
	localparam int QCW    = QAW + 1;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] WCNT_MAX     = 8'hFF;

	typedef enum logic [1:0] {
		MODE_BETWEEN = 2'd0,
		MODE_WORD    = 2'd1,
		MODE_COMMENT = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		QUOTE_NONE   = 2'd0,
		QUOTE_SINGLE = 2'd1,
		QUOTE_DOUBLE = 2'd2
	} quote_t;

	typedef enum logic [1:0] {
		EV_BYTE  = 2'd0,
		EV_END   = 2'd1,
		EV_DONE  = 2'd2,
		EV_ERROR = 2'd3
	} ev_t;

	typedef struct packed {
		ev_t        ev;
		logic [7:0] wbyte;
		logic [7:0] wcount;
	} res_t;

	// one accepted item worth of results, cnt is 1 to 3
	typedef struct packed {
		logic [1:0]     cnt;
		res_t [2:0]     res;
	} cmd_t;

	typedef struct packed {
		logic nonempty;
		cmd_t head;
	} qstat_t;

endpackage

`default_nettype wire

@@ rtl/shell_style_word_splitter.sv @@
// top level of the shell style word splitter
//
// line channel: line_valid, line_stall, line_byte. one byte of a line per
// item, a zero byte closes the line. the block takes one byte per cycle
// while its command queue has room.
// result channel: res_valid, res_stall, event_res, word_byte, word_count,
// last_of_run. each line byte gives zero to three results; last_of_run
// marks the final result of a byte. event codes: word byte, end of word,
// line done ok, line error for an unterminated quote (drop the line).
// a byte's first result goes through a queue entry and then the output
// register. results leave at one per cycle while res_stall is low, so bytes
// with one or no result flow at one per cycle; a byte with three results
// holds the result port until all three have left, and the four entry
// queue absorbs short bursts of those.
// res_stall holds the output register and its payload; once the queue is
// full, line_stall rises until a command drains.
// reset clears scan state, word count, queue and output valid at once.
`default_nettype none

module shell_style_word_splitter (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       line_valid,
	output logic            line_stall,
	input  wire logic [7:0] line_byte,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic [1:0]      event_res,
	output logic [7:0]      word_byte,
	output logic [7:0]      word_count,
	output logic            last_of_run
);
	import ssws_pkg::*;

	logic   push, pop, q_full;
	cmd_t   push_cmd;
	qstat_t stat;

	ssws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_valid (line_valid),
		.line_byte  (line_byte),
		.q_full     (q_full),
		.line_stall (line_stall),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	ssws_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.stat     (stat)
	);

	ssws_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.stat        (stat),
		.res_stall   (res_stall),
		.pop         (pop),
		.res_valid   (res_valid),
		.event_res   (event_res),
		.word_byte   (word_byte),
		.word_count  (word_count),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

@@ rtl/ssws_front.sv @@
// front part: accepts line bytes, tracks scan state, builds result commands
`default_nettype none

module ssws_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          line_valid,
	input  wire logic [7:0]    line_byte,
	input  wire logic          q_full,
	output logic               line_stall,
	output logic               push,
	output ssws_pkg::cmd_t     push_cmd
);
	import ssws_pkg::*;

	mode_t      mode_q, mode_d;
	quote_t     quote_q, quote_d;
	logic       esc_q, esc_d;
	logic [7:0] wd_q, wd_d;
	logic [7:0] wd_inc;
	logic       accept;
	logic       is_sp, is_hash, is_bs, is_sq, is_dq, is_zero;
	logic       in_word, in_comment, starts_word;
	logic [1:0] k, k1;
	logic [7:0] qc;
	cmd_t       cmd;

	assign line_stall = q_full;
	assign accept     = line_valid && !q_full;

	assign is_zero = (line_byte == CH_NUL);
	assign is_sp   = (line_byte == CH_SPACE) || (line_byte >= CH_TAB && line_byte <= CH_CR);
	assign is_hash = (line_byte == CH_HASH);
	assign is_bs   = (line_byte == CH_BACKSLASH);
	assign is_sq   = (line_byte == CH_SQUOTE);
	assign is_dq   = (line_byte == CH_DQUOTE);

	assign wd_inc      = (wd_q == WCNT_MAX) ? wd_q : wd_q + 8'd1;
	assign in_word     = (mode_q == MODE_WORD);
	assign in_comment  = (mode_q == MODE_COMMENT);
	assign starts_word = !in_word && !in_comment && !is_sp && !is_hash;
	assign qc          = (quote_q == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
	assign k           = esc_q ? 2'd1 : 2'd0;
	assign k1          = k + 2'd1;

	always_comb begin
		mode_d  = mode_q;
		quote_d = quote_q;
		esc_d   = esc_q;
		wd_d    = wd_q;
		cmd.cnt = 2'd0;
		for (int i = 0; i < 3; i++) begin
			cmd.res[i] = '{ev: EV_BYTE, wbyte: 8'd0, wcount: wd_q};
		end
		if (is_zero) begin
			if (in_word) begin
				if (esc_q) begin
					cmd.res[0] = '{ev: EV_BYTE, wbyte: CH_BACKSLASH, wcount: wd_q};
				end
				if (quote_q != QUOTE_NONE) begin
					cmd.res[k] = '{ev: EV_ERROR, wbyte: 8'd0, wcount: wd_q};
					cmd.cnt    = k1;
				end else begin
					cmd.res[k]  = '{ev: EV_END, wbyte: 8'd0, wcount: wd_inc};
					cmd.res[k1] = '{ev: EV_DONE, wbyte: 8'd0, wcount: wd_inc};
					cmd.cnt     = k + 2'd2;
				end
			end else begin
				cmd.res[0] = '{ev: EV_DONE, wbyte: 8'd0, wcount: wd_q};
				cmd.cnt    = 2'd1;
			end
			mode_d  = MODE_BETWEEN;
			quote_d = QUOTE_NONE;
			esc_d   = 1'b0;
			wd_d    = 8'd0;
		end else if (in_comment) begin
			mode_d = MODE_COMMENT;
		end else if (in_word || starts_word) begin
			mode_d = MODE_WORD;
			if (esc_q) begin
				esc_d      = 1'b0;
				cmd.res[0] = '{ev: EV_BYTE, wbyte: line_byte, wcount: wd_q};
				cmd.cnt    = 2'd1;
			end else if (quote_q != QUOTE_NONE) begin
				if (line_byte == qc) begin
					quote_d = QUOTE_NONE;
				end else if (is_bs) begin
					esc_d = 1'b1;
				end else begin
					cmd.res[0] = '{ev: EV_BYTE, wbyte: line_byte, wcount: wd_q};
					cmd.cnt    = 2'd1;
				end
			end else if (is_sp || is_hash) begin
				mode_d     = is_hash ? MODE_COMMENT : MODE_BETWEEN;
				wd_d       = wd_inc;
				cmd.res[0] = '{ev: EV_END, wbyte: 8'd0, wcount: wd_inc};
				cmd.cnt    = 2'd1;
			end else if (is_sq) begin
				quote_d = QUOTE_SINGLE;
			end else if (is_dq) begin
				quote_d = QUOTE_DOUBLE;
			end else if (is_bs) begin
				esc_d = 1'b1;
			end else begin
				cmd.res[0] = '{ev: EV_BYTE, wbyte: line_byte, wcount: wd_q};
				cmd.cnt    = 2'd1;
			end
		end else if (is_hash) begin
			mode_d = MODE_COMMENT;
		end
	end

	assign push     = accept && (cmd.cnt != 2'd0);
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BETWEEN;
			quote_q <= QUOTE_NONE;
			esc_q   <= 1'b0;
			wd_q    <= 8'd0;
		end else if (accept) begin
			mode_q  <= mode_d;
			quote_q <= quote_d;
			esc_q   <= esc_d;
			wd_q    <= wd_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/ssws_queue.sv @@
// short command queue between front and back parts
`default_nettype none

module ssws_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire ssws_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output logic               full,
	output ssws_pkg::qstat_t   stat
);
	import ssws_pkg::*;

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	logic           do_pop;

	assign full          = (cnt_q == QCW'(QDEPTH));
	assign stat.nonempty = (cnt_q != '0);
	assign stat.head     = mem_q[rd_ptr_q];
	assign do_pop        = pop && stat.nonempty;

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			unique case ({push && !full, do_pop})
				2'b10:   cnt_q <= cnt_q + QCW'(1);
				2'b01:   cnt_q <= cnt_q - QCW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/ssws_back.sv @@
// back part: walks each command and drives results through the output register
`default_nettype none

module ssws_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ssws_pkg::qstat_t stat,
	input  wire logic            res_stall,
	output logic                 pop,
	output logic                 res_valid,
	output logic [1:0]           event_res,
	output logic [7:0]           word_byte,
	output logic [7:0]           word_count,
	output logic                 last_of_run
);
	import ssws_pkg::*;

	logic [1:0] idx_q;
	logic       load;
	logic       is_last;
	logic       valid_q;
	res_t       cur;
	res_t       res_q;
	logic       last_q;

	assign load    = !valid_q || !res_stall;
	assign cur     = stat.head.res[idx_q];
	assign is_last = (idx_q == stat.head.cnt - 2'd1);
	assign pop     = load && stat.nonempty && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= stat.nonempty;
			if (stat.nonempty) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && stat.nonempty) begin
			res_q  <= cur;
			last_q <= is_last;
		end
	end

	assign res_valid   = valid_q;
	assign event_res   = res_q.ev;
	assign word_byte   = res_q.wbyte;
	assign word_count  = res_q.wcount;
	assign last_of_run = last_q;

endmodule

`default_nettype wire

@@ rtl/ssws_chk.sv @@
// port level checks of the shell style word splitter and their bind
`default_nettype none

module ssws_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       line_valid,
	input wire logic       line_stall,
	input wire logic [7:0] line_byte,
	input wire logic       res_valid,
	input wire logic       res_stall,
	input wire logic [1:0] event_res,
	input wire logic [7:0] word_byte,
	input wire logic [7:0] word_count,
	input wire logic       last_of_run
);
	import ssws_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(event_res) && $stable(word_byte)
			&& $stable(word_count) && $stable(last_of_run))
		else $error("stalled result changed");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (event_res == EV_DONE || event_res == EV_ERROR) |-> last_of_run)
		else $error("line status not last of its item");

	a_mark_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res != EV_BYTE |-> word_byte == 8'd0)
		else $error("mark carries a word byte");

	a_end_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_res == EV_END |-> word_count != 8'd0)
		else $error("end of word without count");

endmodule

bind shell_style_word_splitter ssws_chk u_ssws_chk (.*);

`default_nettype wire
